@@ sv/ghre_pkg.sv @@
// Shared types, constants and helper functions for the gamepad report encoder.
`default_nettype none
package ghre_pkg;

  localparam int MAX_BUTTONS = 32;
  localparam int AXIS_SLOTS  = 8;
  localparam int QUEUE_DEPTH = 4;

  localparam logic [7:0] AXIS_MASK  = 8'((1 << AXIS_SLOTS) - 1);
  localparam logic [3:0] HAT_CENTER = 4'hF;
  localparam logic [7:0] AXIS_REST  = 8'd127;
  localparam logic [9:0] VALUE_MAX  = 10'd1000;

  // v*127/1000 and v*128/1000 as one multiply by a scaled reciprocal
  localparam int          SCALE_SHIFT = 27;
  localparam logic [24:0] MUL_MINUS   = 25'd17045686;
  localparam logic [24:0] MUL_PLUS    = 25'd17179904;

  localparam logic [5:0] CODE_HAT_LAST    = 6'd3;
  localparam logic [5:0] CODE_BUTTON_BASE = 6'd4;
  localparam logic [5:0] CODE_BUTTON_LAST = 6'd35;
  localparam logic [5:0] CODE_AXIS_BASE   = 6'd36;
  localparam logic [5:0] CODE_AXIS_LAST   = 6'd51;

  typedef enum logic [1:0] {
    OP_EVENT  = 2'd0,
    OP_SEND   = 2'd1,
    OP_GET    = 2'd2,
    OP_REINIT = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    REG_BUTTON_COUNT = 2'd0,
    REG_AXIS_MASK    = 2'd1,
    REG_HAT_ENABLE   = 2'd2,
    REG_MATCH_ID     = 2'd3
  } reg_index_t;

  typedef enum logic [2:0] {
    CMD_HAT,
    CMD_BUTTON,
    CMD_AXIS,
    CMD_SEND,
    CMD_GET,
    CMD_REINIT,
    CMD_NOP
  } cmd_kind_t;

  typedef enum logic {
    ST_IDLE,
    ST_EMIT
  } back_state_t;

  typedef struct packed {
    logic [5:0] button_count;
    logic [7:0] axis_mask;
    logic       hat_enable;
    logic [7:0] match_id;
  } cfg_t;

  typedef struct packed {
    cmd_kind_t  kind;
    logic [4:0] index;
    logic       level;
    logic [2:0] slot;
    logic [7:0] value;
  } cmd_t;

  function automatic logic [5:0] eff_buttons(input logic [5:0] count);
    return (count > 6'(MAX_BUTTONS)) ? 6'(MAX_BUTTONS) : count;
  endfunction

  function automatic logic [2:0] button_bytes(input logic [5:0] count);
    logic [6:0] sum;
    sum = {1'b0, eff_buttons(count)} + 7'd7;
    return sum[5:3];
  endfunction

  function automatic logic [3:0] axis_total(input logic [7:0] mask);
    logic [3:0] n;
    n = '0;
    for (int i = 0; i < 8; i++) begin
      n = n + {3'b0, mask[i] & AXIS_MASK[i]};
    end
    return n;
  endfunction

  function automatic logic [3:0] report_size(input cfg_t cfg);
    return {1'b0, button_bytes(cfg.button_count)} + axis_total(cfg.axis_mask)
           + {3'b0, cfg.hat_enable};
  endfunction

  function automatic logic [3:0] hat_from_flags(input logic [3:0] f);
    logic up, dn, east, west;
    up   = f[0] & ~f[1];
    dn   = f[1] & ~f[0];
    east = f[3] & ~f[2];
    west = f[2] & ~f[3];
    if (up)   return east ? 4'd1 : (west ? 4'd7 : 4'd0);
    if (dn)   return east ? 4'd3 : (west ? 4'd5 : 4'd4);
    if (east) return 4'd2;
    if (west) return 4'd6;
    return HAT_CENTER;
  endfunction

endpackage
`default_nettype wire

@@ sv/ghre_front.sv @@
// Front end: accepts input beats, filters and classifies them, scales axis values.
`default_nettype none
module ghre_front (
  input  wire logic            in_valid,
  output logic                 in_stall,
  input  wire logic [1:0]      operation,
  input  wire logic [5:0]      event_code,
  input  wire logic [9:0]      event_value,
  input  wire logic [7:0]      requested_id,
  input  wire logic [6:0]      request_length,
  input  wire ghre_pkg::cfg_t  cfg,
  input  wire logic            q_full,
  output logic                 q_push,
  output ghre_pkg::cmd_t       q_cmd
);
  import ghre_pkg::*;

  logic [5:0]  btn_off;
  logic [5:0]  axis_off;
  logic [2:0]  axis;
  logic [7:0]  mask;
  logic [2:0]  slot;
  logic [9:0]  v_sat;
  logic [34:0] product;
  logic [7:0]  scaled;

  assign btn_off  = event_code - CODE_BUTTON_BASE;
  assign axis_off = event_code - CODE_AXIS_BASE;
  assign axis     = axis_off[3:1];
  assign mask     = cfg.axis_mask & AXIS_MASK;
  assign v_sat    = (event_value > VALUE_MAX) ? VALUE_MAX : event_value;
  assign product  = {25'b0, v_sat} * {10'b0, axis_off[0] ? MUL_PLUS : MUL_MINUS};
  assign scaled   = product[SCALE_SHIFT +: 8] + (axis_off[0] ? AXIS_REST : 8'd0);

  always_comb begin
    slot = '0;
    for (int i = 0; i < AXIS_SLOTS; i++) begin
      if (3'(i) < axis) slot = slot + {2'b0, mask[i]};
    end
  end

  always_comb begin
    q_cmd       = '0;
    q_cmd.kind  = CMD_NOP;
    q_cmd.level = (event_value != 10'd0);
    q_cmd.slot  = slot;
    q_cmd.value = scaled;
    unique case (op_t'(operation))
      OP_EVENT: begin
        if (event_code <= CODE_HAT_LAST) begin
          q_cmd.index = {3'b0, event_code[1:0]};
          if (cfg.hat_enable) q_cmd.kind = CMD_HAT;
        end else if (event_code <= CODE_BUTTON_LAST) begin
          q_cmd.index = btn_off[4:0];
          if (btn_off < eff_buttons(cfg.button_count)) q_cmd.kind = CMD_BUTTON;
        end else if (event_code <= CODE_AXIS_LAST) begin
          if (mask[axis]) q_cmd.kind = CMD_AXIS;
        end
      end
      OP_SEND: q_cmd.kind = CMD_SEND;
      OP_GET: begin
        if (requested_id == cfg.match_id && request_length >= {3'b0, report_size(cfg)})
          q_cmd.kind = CMD_GET;
      end
      OP_REINIT: q_cmd.kind = CMD_REINIT;
      default: q_cmd.kind = CMD_NOP;
    endcase
  end

  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full && (q_cmd.kind != CMD_NOP);

endmodule
`default_nettype wire

@@ sv/ghre_queue.sv @@
// Short command queue between the front and back ends.
`default_nettype none
module ghre_queue (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            push,
  input  wire ghre_pkg::cmd_t  push_cmd,
  output logic                 full,
  output logic                 pop_valid,
  input  wire logic            pop,
  output ghre_pkg::cmd_t       pop_cmd
);
  import ghre_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);

  cmd_t              entries [QUEUE_DEPTH];
  logic [PTR_W-1:0]  head;
  logic [PTR_W-1:0]  tail;
  logic [PTR_W:0]    count;

  assign full      = (count == (PTR_W+1)'(QUEUE_DEPTH));
  assign pop_valid = (count != '0);
  assign pop_cmd   = entries[head];

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      if (push) tail <= tail + 1'b1;
      if (pop)  head <= head + 1'b1;
      count <= count + (PTR_W+1)'(push) - (PTR_W+1)'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) entries[tail] <= push_cmd;
  end

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= (PTR_W+1)'(QUEUE_DEPTH)) else $error("queue over depth");
  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    full |-> !push) else $error("push into full queue");
  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst)
    pop |-> pop_valid) else $error("pop from empty queue");
`endif

endmodule
`default_nettype wire

@@ sv/ghre_back.sv @@
// Back end: holds the report image, applies commands and serialises report beats.
`default_nettype none
module ghre_back (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire ghre_pkg::cfg_t  cfg,
  input  wire logic            q_valid,
  input  wire ghre_pkg::cmd_t  q_cmd,
  output logic                 q_pop,
  output logic                 out_valid,
  input  wire logic            out_stall,
  output logic [7:0]           report_byte,
  output logic                 last_byte
);
  import ghre_pkg::*;

  back_state_t state, state_next;

  logic [31:0] button_bits;
  logic [7:0]  axis_bytes [AXIS_SLOTS];
  logic [3:0]  hat_flags;
  logic [3:0]  hat_code;
  logic        report_dirty;
  logic [3:0]  idx;

  logic [2:0]  nb;
  logic [3:0]  na;
  logic [3:0]  total;
  logic        slot_free;
  logic        load;
  logic        start;
  logic        at_last;
  logic [3:0]  axis_pos;
  logic [7:0]  byte_sel;
  logic [3:0]  flags_next;
  logic [3:0]  hat_next;
  logic [31:0] bits_next;

  assign nb        = button_bytes(cfg.button_count);
  assign na        = axis_total(cfg.axis_mask);
  assign total     = report_size(cfg);
  assign slot_free = !out_valid || !out_stall;
  assign at_last   = (idx == total - 4'd1);
  assign start     = q_valid && total != 4'd0 &&
                     ((q_cmd.kind == CMD_SEND && report_dirty) || q_cmd.kind == CMD_GET);
  assign axis_pos  = idx - {1'b0, nb};

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (start) state_next = ST_EMIT;
      ST_EMIT: if (slot_free && at_last) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    q_pop = 1'b0;
    load  = 1'b0;
    unique case (state)
      ST_IDLE: q_pop = q_valid;
      ST_EMIT: load  = slot_free;
      default: ;
    endcase
  end

  always_comb begin
    if (idx < {1'b0, nb})
      byte_sel = button_bits[{idx[1:0], 3'b000} +: 8];
    else if (idx < {1'b0, nb} + na)
      byte_sel = axis_bytes[axis_pos[2:0]];
    else
      byte_sel = {4'b0, hat_code};
  end

  always_comb begin
    flags_next = hat_flags;
    flags_next[q_cmd.index[1:0]] = q_cmd.level;
    hat_next  = hat_from_flags(flags_next);
    bits_next = button_bits;
    bits_next[q_cmd.index] = q_cmd.level;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      idx          <= '0;
      out_valid    <= 1'b0;
      button_bits  <= '0;
      hat_flags    <= '0;
      hat_code     <= HAT_CENTER;
      report_dirty <= 1'b0;
      for (int i = 0; i < AXIS_SLOTS; i++) axis_bytes[i] <= AXIS_REST;
    end else begin
      state <= state_next;
      if (load) begin
        out_valid <= 1'b1;
        idx       <= idx + 4'd1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      if (q_pop) begin
        idx <= '0;
        case (q_cmd.kind)
          CMD_HAT: begin
            hat_flags <= flags_next;
            if (hat_next != hat_code) begin
              hat_code     <= hat_next;
              report_dirty <= 1'b1;
            end
          end
          CMD_BUTTON: begin
            if (bits_next != button_bits) begin
              button_bits  <= bits_next;
              report_dirty <= 1'b1;
            end
          end
          CMD_AXIS: begin
            if (axis_bytes[q_cmd.slot] != q_cmd.value) begin
              axis_bytes[q_cmd.slot] <= q_cmd.value;
              report_dirty           <= 1'b1;
            end
          end
          CMD_SEND: report_dirty <= 1'b0;
          CMD_REINIT: begin
            button_bits  <= '0;
            hat_flags    <= '0;
            hat_code     <= HAT_CENTER;
            report_dirty <= 1'b1;
            for (int i = 0; i < AXIS_SLOTS; i++) axis_bytes[i] <= AXIS_REST;
          end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      report_byte <= byte_sel;
      last_byte   <= at_last;
    end
  end

`ifndef SYNTH
  a_idx_bound: assert property (@(posedge clk) disable iff (rst)
    state == ST_EMIT |-> idx < total) else $error("beat index beyond report");
  a_no_pop_emit: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> state == ST_IDLE) else $error("command taken while emitting");
  a_last_idle: assert property (@(posedge clk) disable iff (rst)
    load && at_last |=> state == ST_IDLE) else $error("emission ran past last beat");
  a_send_clears: assert property (@(posedge clk) disable iff (rst)
    q_pop && q_cmd.kind == CMD_SEND |=> !report_dirty) else $error("send left dirty set");
`endif

endmodule
`default_nettype wire

@@ sv/gamepad_hid_report_encoder.sv @@
// Top level of the gamepad HID input report encoder.
// Input channel (in_valid/in_stall): one beat per operation - control event,
// send-if-changed, get-report or reinitialise. A beat is taken when in_valid
// is high and in_stall low; in_stall rises only while the four-entry command
// queue is full.
// Output channel (out_valid/out_stall): one beat per report byte, last_byte
// marks the final one. A report is up to 13 beats, one per cycle while the
// receiver does not stall; a stall holds the current beat and the queue
// keeps taking input until it fills.
// Flow: a control event is applied when the back end pops it from the queue
// head; a request moves the back end to its emit state, which loads each byte
// into the single output register. Events sustain one per cycle while no
// report is emitted; the back end pops no command until the last byte loads.
// Configuration (cfg_valid/cfg_ready): cfg_ready is always high; write only
// while the block is idle.
// Reset (rst, synchronous): clears the image (axes to 127, hat centred),
// restores register defaults and empties the queue.
`default_nettype none
module gamepad_hid_report_encoder (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  operation,
  input  wire logic [5:0]  event_code,
  input  wire logic [9:0]  event_value,
  input  wire logic [7:0]  requested_id,
  input  wire logic [6:0]  request_length,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [7:0]       report_byte,
  output logic             last_byte,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [7:0]  cfg_data
);
  import ghre_pkg::*;

  cfg_t cfg;
  cmd_t push_cmd;
  cmd_t head_cmd;
  logic q_push;
  logic q_full;
  logic q_valid;
  logic q_pop;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.button_count <= 6'd16;
      cfg.axis_mask    <= 8'd0;
      cfg.hat_enable   <= 1'b1;
      cfg.match_id     <= 8'd1;
    end else if (cfg_valid && cfg_ready) begin
      unique case (reg_index_t'(cfg_index))
        REG_BUTTON_COUNT: cfg.button_count <= cfg_data[5:0];
        REG_AXIS_MASK:    cfg.axis_mask    <= cfg_data;
        REG_HAT_ENABLE:   cfg.hat_enable   <= cfg_data[0];
        REG_MATCH_ID:     cfg.match_id     <= cfg_data;
        default: ;
      endcase
    end
  end

  ghre_front u_front (
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .operation      (operation),
    .event_code     (event_code),
    .event_value    (event_value),
    .requested_id   (requested_id),
    .request_length (request_length),
    .cfg            (cfg),
    .q_full         (q_full),
    .q_push         (q_push),
    .q_cmd          (push_cmd)
  );

  ghre_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_cmd  (push_cmd),
    .full      (q_full),
    .pop_valid (q_valid),
    .pop       (q_pop),
    .pop_cmd   (head_cmd)
  );

  ghre_back u_back (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .q_valid     (q_valid),
    .q_cmd       (head_cmd),
    .q_pop       (q_pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .report_byte (report_byte),
    .last_byte   (last_byte)
  );

endmodule
`default_nettype wire

@@ test/report_byte_checker.sv @@
// Checker for the gamepad report encoder: tracks the report image, predicts report bytes, compares beats.
`timescale 1ns / 1ps
module report_byte_checker (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic       in_stall,
  input  logic [1:0] operation,
  input  logic [5:0] event_code,
  input  logic [9:0] event_value,
  input  logic [7:0] requested_id,
  input  logic [6:0] request_length,
  input  logic       out_valid,
  input  logic       out_stall,
  input  logic [7:0] report_byte,
  input  logic       last_byte,
  input  logic       cfg_valid,
  input  logic       cfg_ready,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_data,
  output int         outstanding,
  output int         mismatches
);
  import ghre_pkg::*;

  typedef struct packed {
    logic [7:0] octet;
    logic       tail;
  } report_beat_t;

  logic [5:0]   btn_cfg;
  logic [7:0]   axis_cfg;
  logic         hat_on;
  logic [7:0]   id_cfg;

  logic [31:0]  buttons;
  logic [7:0]   axes [8];
  logic [3:0]   hat_dirs;
  logic [3:0]   hat_now;
  logic         changed;

  report_beat_t expected_bytes [$];
  report_beat_t head;
  int           fail_total = 0;

  initial begin
    outstanding = 0;
    mismatches  = 0;
  end

  function automatic int live_buttons();
    return (btn_cfg > MAX_BUTTONS) ? MAX_BUTTONS : int'(btn_cfg);
  endfunction

  function automatic logic [7:0] live_axes();
    return axis_cfg & AXIS_MASK;
  endfunction

  function automatic int report_length();
    return (live_buttons() + 7) / 8 + $countones(live_axes()) + int'(hat_on);
  endfunction

  function automatic void clear_image();
    buttons = '0;
    foreach (axes[i]) axes[i] = AXIS_REST;
    hat_dirs = '0;
    hat_now  = HAT_CENTER;
  endfunction

  // flags: up, down, left, right; opposing pairs cancel; 0 is north, clockwise
  function automatic logic [3:0] compass(logic [3:0] f);
    logic n, s, e, w;
    n = f[0] && !f[1];
    s = f[1] && !f[0];
    w = f[2] && !f[3];
    e = f[3] && !f[2];
    if (n) return e ? 4'd1 : (w ? 4'd7 : 4'd0);
    if (s) return e ? 4'd3 : (w ? 4'd5 : 4'd4);
    if (e) return 4'd2;
    if (w) return 4'd6;
    return HAT_CENTER;
  endfunction

  function automatic logic [7:0] axis_level(logic plus, logic [9:0] raw);
    int v;
    v = (raw > VALUE_MAX) ? int'(VALUE_MAX) : int'(raw);
    return plus ? 8'(127 + v * 128 / 1000) : 8'(v * 127 / 1000);
  endfunction

  function automatic void apply_event(logic [5:0] code, logic [9:0] value);
    logic [3:0]  heading;
    logic [31:0] nb;
    logic [7:0]  mask;
    logic [7:0]  level;
    int          idx;
    int          axis;
    int          slot;
    if (code <= CODE_HAT_LAST) begin
      if (hat_on) begin
        hat_dirs[code[1:0]] = (value != 0);
        heading = compass(hat_dirs);
        if (heading != hat_now) begin
          hat_now = heading;
          changed = 1'b1;
        end
      end
    end else if (code <= CODE_BUTTON_LAST) begin
      idx = code - CODE_BUTTON_BASE;
      if (idx < live_buttons()) begin
        nb      = buttons;
        nb[idx] = (value != 0);
        if (nb != buttons) begin
          buttons = nb;
          changed = 1'b1;
        end
      end
    end else if (code <= CODE_AXIS_LAST) begin
      idx  = code - CODE_AXIS_BASE;
      axis = idx / 2;
      mask = live_axes();
      if (mask[axis]) begin
        slot = 0;
        for (int i = 0; i < axis; i++) slot += mask[i];
        level = axis_level(idx % 2 == 1, value);
        if (axes[slot] != level) begin
          axes[slot] = level;
          changed    = 1'b1;
        end
      end
    end
  endfunction

  function automatic void queue_report();
    int         total;
    int         nbytes;
    int         k;
    int         slot;
    logic [7:0] mask;
    total  = report_length();
    nbytes = (live_buttons() + 7) / 8;
    mask   = live_axes();
    k      = 0;
    slot   = 0;
    for (int i = 0; i < nbytes; i++) begin
      k++;
      expected_bytes.push_back(report_beat_t'{buttons[8*i +: 8], k == total});
    end
    for (int i = 0; i < 8; i++) begin
      if (mask[i]) begin
        k++;
        expected_bytes.push_back(report_beat_t'{axes[slot], k == total});
        slot++;
      end
    end
    if (hat_on) begin
      k++;
      expected_bytes.push_back(report_beat_t'{{4'h0, hat_now}, k == total});
    end
  endfunction

  function automatic void apply_beat(logic [1:0] op, logic [5:0] code, logic [9:0] value,
                                     logic [7:0] rid, logic [6:0] len);
    case (op)
      OP_EVENT: apply_event(code, value);
      OP_SEND: begin
        if (changed) begin
          queue_report();
          changed = 1'b0;
        end
      end
      OP_GET: begin
        if (rid == id_cfg && len >= report_length()) queue_report();
      end
      OP_REINIT: begin
        clear_image();
        changed = 1'b1;
      end
      default: ;
    endcase
  endfunction

  task automatic note_mismatch(string what);
    fail_total++;
    $display("%0t ns mismatch: %s", $time, what);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      btn_cfg  = 6'd16;
      axis_cfg = 8'h00;
      hat_on   = 1'b1;
      id_cfg   = 8'h01;
      clear_image();
      changed  = 1'b0;
      expected_bytes.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_bytes.size() == 0) begin
          note_mismatch($sformatf("unexpected report byte %02h", report_byte));
        end else begin
          head = expected_bytes.pop_front();
          if (report_byte !== head.octet)
            note_mismatch($sformatf("report_byte %02h, want %02h", report_byte, head.octet));
          if (last_byte !== head.tail)
            note_mismatch($sformatf("last_byte %b, want %b", last_byte, head.tail));
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_BUTTON_COUNT: btn_cfg  = cfg_data[5:0];
          REG_AXIS_MASK:    axis_cfg = cfg_data;
          REG_HAT_ENABLE:   hat_on   = cfg_data[0];
          REG_MATCH_ID:     id_cfg   = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && !in_stall)
        apply_beat(operation, event_code, event_value, requested_id, request_length);
    end
    outstanding <= expected_bytes.size();
    mismatches  <= fail_total;
  end

endmodule

@@ test/gamepad_hid_report_encoder_tb.sv @@
// Testbench top for the gamepad report encoder: clock, reset, stimulus, configuration and verdict.
`timescale 1ns / 1ps
module gamepad_hid_report_encoder_tb;
  import ghre_pkg::*;

  logic       clk;
  logic       rst            = 1'b1;
  logic       in_valid       = 1'b0;
  logic       in_stall;
  logic [1:0] operation      = '0;
  logic [5:0] event_code     = '0;
  logic [9:0] event_value    = '0;
  logic [7:0] requested_id   = '0;
  logic [6:0] request_length = '0;
  logic       out_valid;
  logic       out_stall      = 1'b0;
  logic [7:0] report_byte;
  logic       last_byte;
  logic       cfg_valid      = 1'b0;
  logic       cfg_ready;
  logic [1:0] cfg_index      = '0;
  logic [7:0] cfg_data       = '0;

  int         outstanding;
  int         mismatches;
  logic       steady         = 1'b0;
  logic [7:0] id_now         = 8'h01;

  gamepad_hid_report_encoder dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .operation      (operation),
    .event_code     (event_code),
    .event_value    (event_value),
    .requested_id   (requested_id),
    .request_length (request_length),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .report_byte    (report_byte),
    .last_byte      (last_byte),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  report_byte_checker byte_check (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .operation      (operation),
    .event_code     (event_code),
    .event_value    (event_value),
    .requested_id   (requested_id),
    .request_length (request_length),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .report_byte    (report_byte),
    .last_byte      (last_byte),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .outstanding    (outstanding),
    .mismatches     (mismatches)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  always @(posedge clk) begin
    out_stall <= !steady && ($urandom_range(0, 99) < 29);
  end

  initial begin
    #(2_400_000);
    $display("CHECK FAILED");
    $finish;
  end

  task automatic write_reg(reg_index_t idx, logic [7:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic load_setting(logic [7:0] count, logic [7:0] mask, logic [7:0] hat,
                              logic [7:0] id);
    write_reg(REG_BUTTON_COUNT, count);
    write_reg(REG_AXIS_MASK, mask);
    write_reg(REG_HAT_ENABLE, hat);
    write_reg(REG_MATCH_ID, id);
    cfg_valid <= 1'b0;
    id_now = id;
  endtask

  task automatic issue(op_t op, logic [5:0] code, logic [9:0] value, logic [7:0] rid,
                       logic [6:0] len);
    while (!steady && $urandom_range(0, 99) < 29) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid       <= 1'b1;
    operation      <= op;
    event_code     <= code;
    event_value    <= value;
    requested_id   <= rid;
    request_length <= len;
    do @(posedge clk); while (in_stall);
  endtask

  // drain every outstanding report byte, then let queued events retire
  task automatic settle();
    in_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (12) @(posedge clk);
  endtask

  task automatic random_op();
    int         pick;
    int         kind;
    logic [5:0] code;
    logic [9:0] value;
    logic [7:0] rid;
    logic [6:0] len;
    pick  = $urandom_range(0, 99);
    code  = 6'($urandom_range(0, 63));
    value = 10'($urandom_range(0, 1023));
    rid   = 8'($urandom_range(0, 255));
    len   = 7'($urandom_range(0, 127));
    if (pick < 66) begin
      kind = $urandom_range(0, 9);
      if (kind < 2) code = 6'($urandom_range(0, 3));
      else if (kind < 6) code = 6'($urandom_range(4, 35));
      else if (kind < 9) code = 6'($urandom_range(36, 51));
      kind = $urandom_range(0, 3);
      if (kind == 0) value = '0;
      else if (kind == 1) value = VALUE_MAX;
      issue(OP_EVENT, code, value, rid, len);
    end else if (pick < 80) begin
      issue(OP_SEND, code, value, rid, len);
    end else if (pick < 96) begin
      if ($urandom_range(0, 3) != 0) rid = id_now;
      if ($urandom_range(0, 4) != 0) len = 7'($urandom_range(0, 16));
      issue(OP_GET, code, value, rid, len);
    end else begin
      issue(OP_REINIT, code, value, rid, len);
    end
  endtask

  // {button_count, axis mask, hat enable, report id}
  function automatic logic [31:0] phase_setting(int p);
    case (p)
      0:       return {8'h3F, 8'hA5, 8'h00, 8'hFF};
      1:       return {8'h00, 8'h00, 8'h00, 8'h00};
      2:       return {8'h7F, 8'h81, 8'h01, 8'h00};
      3:       return {8'h01, 8'h3C, 8'h01, 8'h80};
      4:       return {8'h09, 8'hFF, 8'h00, 8'h01};
      default: return {8'h18, 8'h10, 8'h01, 8'hC3};
    endcase
  endfunction

  initial begin
    logic [31:0] s;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // full-size report: four button bytes, eight axes, hat
    load_setting(8'd32, 8'hFF, 8'h01, 8'h5A);
    issue(OP_EVENT, 6'd4, 10'd1, 8'h00, 7'd0);
    issue(OP_EVENT, 6'd35, 10'd1000, 8'h00, 7'd0);
    issue(OP_EVENT, 6'd36, 10'd0, 8'h00, 7'd0);
    issue(OP_EVENT, 6'd37, 10'd1000, 8'h00, 7'd0);
    issue(OP_EVENT, 6'd51, 10'd1023, 8'h00, 7'd0);
    issue(OP_EVENT, 6'd48, 10'd500, 8'h00, 7'd0);
    issue(OP_EVENT, 6'd0, 10'd1, 8'h00, 7'd0);
    issue(OP_EVENT, 6'd3, 10'd1, 8'h00, 7'd0);
    issue(OP_EVENT, 6'd2, 10'd1, 8'h00, 7'd0);
    issue(OP_EVENT, 6'd1, 10'd1, 8'h00, 7'd0);
    issue(OP_EVENT, 6'd52, 10'd1, 8'h00, 7'd0);
    issue(OP_EVENT, 6'd63, 10'd1023, 8'hFF, 7'd127);
    issue(OP_SEND, 6'd0, 10'd0, 8'h00, 7'd0);
    issue(OP_SEND, 6'd0, 10'd0, 8'h00, 7'd0);
    issue(OP_GET, 6'd0, 10'd0, 8'h5A, 7'd13);
    issue(OP_GET, 6'd0, 10'd0, 8'h5A, 7'd12);
    issue(OP_GET, 6'd0, 10'd0, 8'h5B, 7'd127);
    issue(OP_EVENT, 6'd35, 10'd0, 8'h00, 7'd0);
    issue(OP_EVENT, 6'd0, 10'd0, 8'h00, 7'd0);
    issue(OP_GET, 6'd0, 10'd0, 8'h5A, 7'd127);
    issue(OP_REINIT, 6'd0, 10'd0, 8'h00, 7'd0);
    issue(OP_SEND, 6'd0, 10'd0, 8'h00, 7'd0);
    issue(OP_SEND, 6'd0, 10'd0, 8'h00, 7'd0);

    for (int p = 0; p < 6; p++) begin
      settle();
      steady = (p == 3);
      s = phase_setting(p);
      load_setting(s[31:24], s[23:16], s[15:8], s[7:0]);
      for (int n = 0; n < 31; n++) begin
        if (n == 17) settle();
        random_op();
      end
    end

    settle();
    if (mismatches == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

endmodule
